/* rtl/core/jts_pkg.sv */
// jts_pkg: widths, payload types and register codes for the jittered
// triangle sample test. No dependencies; every other file imports it.

package jts_pkg;

	localparam int COORD_BITS  = 24;
	localparam int SAMPLE_BITS = 23;
	localparam int SUB_BITS    = 3;
	localparam int JIT_BITS    = 10;
	localparam int CFG_BITS    = 4;

	// jittered sample: unsigned sample plus at most 0x3fc
	localparam int POS_BITS    = SAMPLE_BITS + 1;
	// vertex minus jittered sample, signed, never overflows
	localparam int REL_BITS    = ((COORD_BITS > POS_BITS) ? COORD_BITS : POS_BITS) + 2;
	localparam int PROD_BITS   = 2 * REL_BITS;
	localparam int DIFF_BITS   = PROD_BITS + 1;

	localparam logic [3:0] SUBPIXEL_RESET = 4'd10;
	localparam logic [1:0] SS_LOG2_RESET  = 2'd2;

	typedef enum logic [0:0] {
		REG_SUBPIXEL_BITS = 1'b0,
		REG_SS_LOG2       = 1'b1
	} cfg_reg_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [SAMPLE_BITS-1:0]       sample_t;
	typedef logic [SUB_BITS-1:0]          sub_t;
	typedef logic [POS_BITS-1:0]          pos_t;
	typedef logic signed [REL_BITS-1:0]   rel_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;

	// pixel and subsample info, carried untouched down the pipe
	typedef struct packed {
		sample_t pixel_x;
		sample_t pixel_y;
		sub_t    sub_x;
		sub_t    sub_y;
	} tag_t;

	// first stage output toward the edge tests
	typedef struct packed {
		coord_t v0x;
		coord_t v0y;
		coord_t v1x;
		coord_t v1y;
		coord_t v2x;
		coord_t v2y;
		pos_t   px;
		pos_t   py;
		tag_t   tag;
	} stage_t;

endpackage

/* rtl/core/jts_sample_if.sv */
// jts_sample_if: input channel, triangle vertices plus one grid sample.
// Depends on jts_pkg.

interface jts_sample_if;
	import jts_pkg::*;

	logic    valid;
	logic    ready;
	coord_t  vert0_x;
	coord_t  vert0_y;
	coord_t  vert1_x;
	coord_t  vert1_y;
	coord_t  vert2_x;
	coord_t  vert2_y;
	sample_t sample_x;
	sample_t sample_y;

	modport source (output valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
		sample_x, sample_y, input ready);
	modport sink (input valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
		sample_x, sample_y, output ready);
endinterface

/* rtl/core/jts_result_if.sv */
// jts_result_if: output channel, hit flag, pixel and subsample index.
// Depends on jts_pkg.

interface jts_result_if;
	import jts_pkg::*;

	logic    valid;
	logic    ready;
	logic    hit;
	sample_t pixel_x;
	sample_t pixel_y;
	sub_t    sub_x;
	sub_t    sub_y;

	modport source (output valid, hit, pixel_x, pixel_y, sub_x, sub_y, input ready);
	modport sink (input valid, hit, pixel_x, pixel_y, sub_x, sub_y, output ready);
endinterface

/* rtl/core/jts_jitter.sv */
// jts_jitter: stage 1, hashes the sample into its jitter offset, forms the
// jittered point and the pixel / subsample fields. Depends on jts_pkg, jts_sample_if.

module jts_jitter (
	input  logic            clk,
	input  logic            arst_n,
	jts_sample_if.sink      sample,
	input  logic [3:0]      subpixel_bits,
	input  logic [1:0]      ss_log2,
	output logic            out_valid,
	input  logic            out_ready,
	output jts_pkg::stage_t out_data
);
	import jts_pkg::*;

	logic   valid_s1;
	stage_t data_s1;
	logic   rdy_s1;
	stage_t data_d;

	// 40-bit word (hi<<20)|lo folded to one byte is byte0 ^ byte4
	function automatic logic [JIT_BITS-1:0] jitter(input logic [SAMPLE_BITS-5:0] lo,
		input logic [SAMPLE_BITS-5:0] hi, input logic [1:0] s);
		logic [39:0] w;
		logic [7:0]  b;
		w = {1'b0, hi, 1'b0, lo};
		b = (w[7:0] ^ w[39:32]) & (8'hff >> s);
		return {b, 2'b00};
	endfunction

	function automatic sub_t sub_index(input sample_t v, input logic [3:0] r,
		input logic [1:0] s);
		sample_t    frac;
		logic [3:0] sh;
		frac = v & ~({SAMPLE_BITS{1'b1}} << r);
		sh   = (r > {2'b00, s}) ? (r - {2'b00, s}) : 4'd0;
		return SUB_BITS'(frac >> sh);
	endfunction

	always_comb begin
		data_d.v0x = sample.vert0_x;
		data_d.v0y = sample.vert0_y;
		data_d.v1x = sample.vert1_x;
		data_d.v1y = sample.vert1_y;
		data_d.v2x = sample.vert2_x;
		data_d.v2y = sample.vert2_y;
		data_d.px  = POS_BITS'(sample.sample_x) + POS_BITS'(jitter(
			sample.sample_x[SAMPLE_BITS-1:4], sample.sample_y[SAMPLE_BITS-1:4], ss_log2));
		data_d.py  = POS_BITS'(sample.sample_y) + POS_BITS'(jitter(
			sample.sample_y[SAMPLE_BITS-1:4], sample.sample_x[SAMPLE_BITS-1:4], ss_log2));
		data_d.tag.pixel_x = sample.sample_x >> subpixel_bits;
		data_d.tag.pixel_y = sample.sample_y >> subpixel_bits;
		data_d.tag.sub_x   = sub_index(sample.sample_x, subpixel_bits, ss_log2);
		data_d.tag.sub_y   = sub_index(sample.sample_y, subpixel_bits, ss_log2);
	end

	assign rdy_s1       = !valid_s1 || out_ready;
	assign sample.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && sample.valid) begin
			data_s1 <= data_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

/* rtl/core/jts_edge.sv */
// jts_edge: stages 2 to 4, relative vertices, edge products, signs and hit.
// Depends on jts_pkg, jts_result_if.

module jts_edge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  jts_pkg::stage_t in_data,
	jts_result_if.source    result
);
	import jts_pkg::*;

	logic  val_s2, val_s3, val_s4;
	logic  rdy_s2, rdy_s3, rdy_s4;
	rel_t  rx_s2 [3];
	rel_t  ry_s2 [3];
	tag_t  tag_s2, tag_s3, tag_s4;
	prod_t pa_s3 [3];
	prod_t pb_s3 [3];
	logic  hit_s4;
	diff_t d0, d1, d2;

	assign rdy_s4   = !val_s4 || result.ready;
	assign rdy_s3   = !val_s3 || rdy_s4;
	assign rdy_s2   = !val_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
			val_s4 <= 1'b0;
		end else begin
			if (rdy_s2) val_s2 <= in_valid;
			if (rdy_s3) val_s3 <= val_s2;
			if (rdy_s4) val_s4 <= val_s3;
		end
	end

	// stage 2: move the jittered point to the origin
	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			rx_s2[0] <= REL_BITS'(in_data.v0x) - $signed(REL_BITS'(in_data.px));
			ry_s2[0] <= REL_BITS'(in_data.v0y) - $signed(REL_BITS'(in_data.py));
			rx_s2[1] <= REL_BITS'(in_data.v1x) - $signed(REL_BITS'(in_data.px));
			ry_s2[1] <= REL_BITS'(in_data.v1y) - $signed(REL_BITS'(in_data.py));
			rx_s2[2] <= REL_BITS'(in_data.v2x) - $signed(REL_BITS'(in_data.px));
			ry_s2[2] <= REL_BITS'(in_data.v2y) - $signed(REL_BITS'(in_data.py));
			tag_s2   <= in_data.tag;
		end
	end

	// stage 3: the six cross products, one multiplier each
	always_ff @(posedge clk) begin
		if (rdy_s3 && val_s2) begin
			pa_s3[0] <= rx_s2[0] * ry_s2[1];
			pb_s3[0] <= rx_s2[1] * ry_s2[0];
			pa_s3[1] <= rx_s2[1] * ry_s2[2];
			pb_s3[1] <= rx_s2[2] * ry_s2[1];
			pa_s3[2] <= rx_s2[2] * ry_s2[0];
			pb_s3[2] <= rx_s2[0] * ry_s2[2];
			tag_s3   <= tag_s2;
		end
	end

	// stage 4: edge values and the fill rule, middle edge strict
	always_comb begin
		d0 = DIFF_BITS'(pa_s3[0]) - DIFF_BITS'(pb_s3[0]);
		d1 = DIFF_BITS'(pa_s3[1]) - DIFF_BITS'(pb_s3[1]);
		d2 = DIFF_BITS'(pa_s3[2]) - DIFF_BITS'(pb_s3[2]);
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && val_s3) begin
			hit_s4 <= (d0 <= 0) && (d1 < 0) && (d2 <= 0);
			tag_s4 <= tag_s3;
		end
	end

	assign result.valid   = val_s4;
	assign result.hit     = hit_s4;
	assign result.pixel_x = tag_s4.pixel_x;
	assign result.pixel_y = tag_s4.pixel_y;
	assign result.sub_x   = tag_s4.sub_x;
	assign result.sub_y   = tag_s4.sub_y;

`ifndef SYNTHESIS
	a_enter_s2: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> val_s2)
		else $error("beat accepted into stage 2 was dropped");
	a_move_s3: assert property (@(posedge clk) disable iff (!arst_n)
		val_s2 && rdy_s3 |=> val_s3)
		else $error("beat lost between stage 2 and stage 3");
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		val_s3 && !rdy_s4 |=> val_s3 && $stable(pa_s3[1]) && $stable(tag_s3))
		else $error("stalled stage 3 beat changed");
`endif

endmodule

/* rtl/core/jittered_triangle_sample_test.sv */
// jittered_triangle_sample_test: top level, configuration registers and the
// jitter and edge pipeline. Depends on jts_pkg, jts_*_if, jts_jitter, jts_edge.
//
//  channel  | direction | handshake     | beat contents
//  sample   | in        | valid/ready   | three vertices, grid sample x/y
//  result   | out       | valid/ready   | hit, pixel x/y, subsample x/y
//  cfg      | in        | cfg_we only   | cfg_idx selects register, cfg_data
//
// One beat per cycle sustained while the result side stays ready; a result passes
// through four register stages after its sample beat is accepted (hash, relative
// vertices, products, edge signs).
// Each stage holds while the next one is full, so a stalled result does not
// block beats from filling bubbles behind it.
// Reset clears the valid bits and loads subpixel_bits = 10, log2 subsamples = 2.

module jittered_triangle_sample_test (
	input  logic                clk,
	input  logic                arst_n,
	jts_sample_if.sink          sample,
	jts_result_if.source        result,
	input  logic                cfg_we,
	input  jts_pkg::cfg_reg_t   cfg_idx,
	input  logic [jts_pkg::CFG_BITS-1:0] cfg_data
);
	import jts_pkg::*;

	logic [3:0] subpixel_bits_q;
	logic [1:0] ss_log2_q;
	logic       mid_valid;
	logic       mid_ready;
	stage_t     mid_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subpixel_bits_q <= SUBPIXEL_RESET;
			ss_log2_q       <= SS_LOG2_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SUBPIXEL_BITS: subpixel_bits_q <= cfg_data[3:0];
				REG_SS_LOG2:       ss_log2_q       <= cfg_data[1:0];
			endcase
		end
	end

	jts_jitter u_jitter (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample        (sample),
		.subpixel_bits (subpixel_bits_q),
		.ss_log2       (ss_log2_q),
		.out_valid     (mid_valid),
		.out_ready     (mid_ready),
		.out_data      (mid_data)
	);

	jts_edge u_edge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mid_valid),
		.in_ready (mid_ready),
		.in_data  (mid_data),
		.result   (result)
	);

endmodule

/* dv/jittered_triangle_sample_test_tb.sv */
`timescale 1ns / 1ps
// jittered_triangle_sample_test_tb: self-checking bench for the jittered triangle
// sample test. Randomized vertex/sample beats, in-bench predictor, scoreboard.
// Depends on jts_pkg, jts_sample_if, jts_result_if and the DUT.

module jittered_triangle_sample_test_tb;
	import jts_pkg::*;

	typedef struct packed {
		coord_t  vert0_x;
		coord_t  vert0_y;
		coord_t  vert1_x;
		coord_t  vert1_y;
		coord_t  vert2_x;
		coord_t  vert2_y;
		sample_t sample_x;
		sample_t sample_y;
	} sample_beat_t;

	typedef struct packed {
		logic    hit;
		sample_t pixel_x;
		sample_t pixel_y;
		sub_t    sub_x;
		sub_t    sub_y;
	} result_beat_t;

	// vertex offsets from the jittered point: v0x, v0y, v1x, v1y, v2x, v2y
	typedef longint rel_set_t [6];

	localparam coord_t  COORD_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam coord_t  COORD_MAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
	localparam int      PHASES     = 8;
	localparam int      RANDOM_PER_PHASE = 115;
	localparam int      LONG_HOLD  = 120;
	localparam int      PRINT_CAP  = 50;

	logic [3:0] phase_subpixel [PHASES] = '{4'd4, 4'd12, 4'd15, 4'd0, 4'd1, 4'd7, 4'd10, 4'd0};
	logic [1:0] phase_ss_log2  [PHASES] = '{2'd0, 2'd3, 2'd0, 2'd3, 2'd2, 2'd1, 2'd2, 2'd0};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	cfg_reg_t            cfg_idx;
	logic [CFG_BITS-1:0] cfg_data;

	jts_sample_if sample_ch ();
	jts_result_if result_ch ();

	jittered_triangle_sample_test DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// bench copy of the configuration
	logic [3:0] subpixel_cfg = SUBPIXEL_RESET;
	logic [1:0] ss_log2_cfg  = SS_LOG2_RESET;

	sample_beat_t pending_samples [$];
	result_beat_t expected_results [$];

	int  error_count    = 0;
	int  accepted_count = 0;
	int  result_count   = 0;
	int  inside_count   = 0;
	int  settings_seen  = 1;
	int  hold_requests  = 0;
	int  holds_served   = 0;
	int  tx_gap         = 0;
	int  rx_gap         = 0;
	int  rx_hold        = 0;
	bit  no_idle        = 1'b0;
	bit  sample_fire    = 1'b0;

	always #10 clk = ~clk;

	// ---------------- predictor ----------------

	// Grid sample plus its hash jitter. The pairwise fold of the five hash
	// bytes collapses to lowest byte xor highest byte.
	function automatic pos_t jittered_coord(sample_t own, sample_t other);
		logic [39:0] word;
		logic [7:0]  fold;
		logic [9:0]  jit;
		word = (40'(other >> 4) << 20) | 40'(own >> 4);
		fold = word[7:0] ^ word[39:32];
		jit  = {2'b00, fold & (8'hff >> ss_log2_cfg)} << 2;
		return pos_t'(own) + pos_t'(jit);
	endfunction

	function automatic result_beat_t predict_result(sample_beat_t s);
		pos_t         px, py;
		longint       ax, ay, bx, by, cx, cy;
		longint       e01, e12, e20;
		logic [3:0]   shift;
		sample_t      frac_mask;
		result_beat_t r;
		px = jittered_coord(s.sample_x, s.sample_y);
		py = jittered_coord(s.sample_y, s.sample_x);
		ax = longint'($signed(s.vert0_x)) - longint'(px);
		ay = longint'($signed(s.vert0_y)) - longint'(py);
		bx = longint'($signed(s.vert1_x)) - longint'(px);
		by = longint'($signed(s.vert1_y)) - longint'(py);
		cx = longint'($signed(s.vert2_x)) - longint'(px);
		cy = longint'($signed(s.vert2_y)) - longint'(py);
		e01 = ax * by - bx * ay;
		e12 = bx * cy - cx * by;
		e20 = cx * ay - ax * cy;
		// edge 1-2 is strict, the other two include the boundary
		r.hit = (e01 <= 0) && (e12 < 0) && (e20 <= 0);
		frac_mask = (sample_t'(1) << subpixel_cfg) - sample_t'(1);
		shift = (subpixel_cfg > {2'b00, ss_log2_cfg}) ? subpixel_cfg - {2'b00, ss_log2_cfg} : 4'd0;
		r.pixel_x = s.sample_x >> subpixel_cfg;
		r.pixel_y = s.sample_y >> subpixel_cfg;
		r.sub_x   = sub_t'((s.sample_x & frac_mask) >> shift);
		r.sub_y   = sub_t'((s.sample_y & frac_mask) >> shift);
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic coord_t clamp_coord(longint v);
		if (v > longint'(COORD_MAX))
			return COORD_MAX;
		if (v < longint'(COORD_MIN))
			return COORD_MIN;
		return coord_t'(v);
	endfunction

	// place a triangle relative to the jittered point of (sx, sy)
	function automatic sample_beat_t shaped_sample(sample_t sx, sample_t sy, rel_set_t rel);
		sample_beat_t s;
		longint       px, py;
		px = longint'(jittered_coord(sx, sy));
		py = longint'(jittered_coord(sy, sx));
		s.sample_x = sx;
		s.sample_y = sy;
		s.vert0_x  = clamp_coord(px + rel[0]);
		s.vert0_y  = clamp_coord(py + rel[1]);
		s.vert1_x  = clamp_coord(px + rel[2]);
		s.vert1_y  = clamp_coord(py + rel[3]);
		s.vert2_x  = clamp_coord(px + rel[4]);
		s.vert2_y  = clamp_coord(py + rel[5]);
		return s;
	endfunction

	function automatic longint rand_offset(int k);
		return longint'($urandom_range(0, 1 << (k + 1))) - (longint'(1) << k);
	endfunction

	function automatic sample_t rand_sample_coord();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			return '0;
		if (roll < 8)
			return SAMPLE_MAX;
		if (roll < 35)
			return sample_t'($urandom_range(0, 4095));
		return sample_t'($urandom);
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	task automatic queue_directed_samples();
		longint  d;
		sample_t sx, sy;
		d  = 100;
		sx = 23'h12345;
		sy = 23'h6789a;
		pending_samples.push_back(sample_beat_t'('0));
		pending_samples.push_back(sample_beat_t'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, SAMPLE_MAX, SAMPLE_MAX});
		pending_samples.push_back(sample_beat_t'{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, sample_t'(0), sample_t'(0)});
		// huge triangle, products near full width, both windings
		pending_samples.push_back(sample_beat_t'{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
			coord_t'(24'h400000), COORD_MIN, sample_t'(23'h400000), sample_t'(23'h400000)});
		pending_samples.push_back(sample_beat_t'{COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX,
			coord_t'(24'h400000), COORD_MIN, sample_t'(23'h400000), sample_t'(23'h400000)});
		// largest hash on x, then on y
		pending_samples.push_back(shaped_sample(23'h000ff0, 23'h0, '{0, d, d, -d, -d, -d}));
		pending_samples.push_back(shaped_sample(23'h0, 23'h000ff0, '{0, d, d, -d, -d, -d}));
		pending_samples.push_back(shaped_sample(SAMPLE_MAX, SAMPLE_MAX, '{0, d, -d, -d, d, -d}));
		// winding, points on each edge, degenerate triangle, vertex on the point
		pending_samples.push_back(shaped_sample(sx, sy, '{0, d, d, -d, -d, -d}));
		pending_samples.push_back(shaped_sample(sx, sy, '{0, d, -d, -d, d, -d}));
		pending_samples.push_back(shaped_sample(sx, sy, '{-d, 0, d, 0, 0, -d}));
		pending_samples.push_back(shaped_sample(sx, sy, '{0, -d, -d, 0, d, 0}));
		pending_samples.push_back(shaped_sample(sx, sy, '{d, 0, 0, -d, -d, 0}));
		pending_samples.push_back(shaped_sample(sx, sy, '{7, 7, 7, 7, 7, 7}));
		pending_samples.push_back(shaped_sample(sx, sy, '{0, 0, d, -d, -d, -d}));
		pending_samples.push_back(shaped_sample(sx, sy, '{0, 0, -d, -d, d, -d}));
		// all fractional bits set
		pending_samples.push_back(shaped_sample(23'h3ff, 23'h3ff, '{0, d, d, -d, -d, -d}));
		pending_samples.push_back(sample_beat_t'{coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			sample_t'(23'h155555), sample_t'(23'h2aaaaa)});
	endtask

	// mostly triangles around the jittered point, some on an edge, rest noise
	task automatic queue_random_samples(int count);
		sample_beat_t s;
		rel_set_t     rel;
		sample_t      sx, sy;
		int           roll, k, side, nxt;
		longint       m;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			sx   = rand_sample_coord();
			sy   = rand_sample_coord();
			k    = $urandom_range(1, 22);
			for (int j = 0; j < 6; j++)
				rel[j] = rand_offset(k);
			if (roll < 25) begin
				s = sample_beat_t'{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), sx, sy};
			end else if (roll < 50) begin
				// the point lands on one edge: its far vertex is the near one mirrored and scaled by m
				side = $urandom_range(0, 2);
				nxt  = (side + 1) % 3;
				m    = $urandom_range(1, 3);
				rel[2*nxt]   = -rel[2*side] * m;
				rel[2*nxt+1] = -rel[2*side+1] * m;
				s = shaped_sample(sx, sy, rel);
			end else begin
				s = shaped_sample(sx, sy, rel);
			end
			pending_samples.push_back(s);
		end
	endtask

	task automatic write_register(cfg_reg_t idx, logic [CFG_BITS-1:0] data);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SUBPIXEL_BITS)
			subpixel_cfg = data;
		else
			ss_log2_cfg = data[1:0];
	endtask

	// sampled at the rising edge, after the driver's falling-edge update has landed
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_samples.size() != 0 || sample_ch.valid || expected_results.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	// ---------------- checking ----------------

	task automatic report_mismatch(string field, longint got, longint want);
		if (error_count < PRINT_CAP)
			$display("%0t mismatch on result %0d, %s: got %0d, expected %0d",
				$time, result_count, field, got, want);
		error_count++;
	endtask

	task automatic check_result(result_beat_t got);
		result_beat_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("unexpected beat", 1, 0);
		end else begin
			want = expected_results.pop_front();
			if (got.hit !== want.hit)
				report_mismatch("hit", got.hit, want.hit);
			if (got.pixel_x !== want.pixel_x)
				report_mismatch("pixel_x", got.pixel_x, want.pixel_x);
			if (got.pixel_y !== want.pixel_y)
				report_mismatch("pixel_y", got.pixel_y, want.pixel_y);
			if (got.sub_x !== want.sub_x)
				report_mismatch("sub_x", got.sub_x, want.sub_x);
			if (got.sub_y !== want.sub_y)
				report_mismatch("sub_y", got.sub_y, want.sub_y);
		end
		result_count++;
	endtask

	// ---------------- driver, receiver, monitor ----------------

	always @(negedge clk) begin
		if (!sample_ch.valid || sample_fire) begin
			if (tx_gap > 0) begin
				sample_ch.valid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (pending_samples.size() != 0) begin
				sample_beat_t s;
				s = pending_samples.pop_front();
				sample_ch.valid    <= 1'b1;
				sample_ch.vert0_x  <= s.vert0_x;
				sample_ch.vert0_y  <= s.vert0_y;
				sample_ch.vert1_x  <= s.vert1_x;
				sample_ch.vert1_y  <= s.vert1_y;
				sample_ch.vert2_x  <= s.vert2_x;
				sample_ch.vert2_y  <= s.vert2_y;
				sample_ch.sample_x <= s.sample_x;
				sample_ch.sample_y <= s.sample_y;
				tx_gap <= no_idle ? 0 : pick_gap();
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			result_ch.ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (holds_served != hold_requests) begin
			// long back-pressure: pipe fills and input ready drops
			result_ch.ready <= 1'b0;
			rx_hold <= LONG_HOLD;
			holds_served <= holds_served + 1;
		end else if (rx_gap > 0) begin
			result_ch.ready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else begin
			result_ch.ready <= 1'b1;
			if (!no_idle && $urandom_range(0, 99) < 25)
				rx_gap <= pick_gap();
		end
	end

	always @(posedge clk) begin
		sample_fire <= sample_ch.valid && sample_ch.ready;
		if (sample_ch.valid && sample_ch.ready) begin
			result_beat_t want;
			want = predict_result(sample_beat_t'{sample_ch.vert0_x, sample_ch.vert0_y,
				sample_ch.vert1_x, sample_ch.vert1_y, sample_ch.vert2_x, sample_ch.vert2_y,
				sample_ch.sample_x, sample_ch.sample_y});
			expected_results.push_back(want);
			accepted_count++;
			if (want.hit)
				inside_count++;
		end
		if (result_ch.valid && result_ch.ready)
			check_result(result_beat_t'{result_ch.hit, result_ch.pixel_x, result_ch.pixel_y,
				result_ch.sub_x, result_ch.sub_y});
	end

	// ---------------- sequence ----------------

	initial begin
		logic [3:0] sp;
		logic [1:0] sl;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_idx            = REG_SUBPIXEL_BITS;
		cfg_data           = '0;
		sample_ch.valid    = 1'b0;
		sample_ch.vert0_x  = '0;
		sample_ch.vert0_y  = '0;
		sample_ch.vert1_x  = '0;
		sample_ch.vert1_y  = '0;
		sample_ch.vert2_x  = '0;
		sample_ch.vert2_y  = '0;
		sample_ch.sample_x = '0;
		sample_ch.sample_y = '0;
		result_ch.ready    = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset configuration
		@(posedge clk);
		queue_directed_samples();
		queue_random_samples(90);
		wait_idle();

		for (int ph = 0; ph < PHASES; ph++) begin
			sp = phase_subpixel[ph];
			sl = phase_ss_log2[ph];
			if (ph == PHASES - 1) begin
				sp = 4'($urandom_range(0, 15));
				sl = 2'($urandom_range(0, 3));
			end
			write_register(REG_SUBPIXEL_BITS, sp);
			// upper data bits are don't-care for the 2-bit register
			write_register(REG_SS_LOG2, {2'($urandom_range(0, 3)), sl});
			settings_seen++;
			@(posedge clk);
			no_idle = (ph == 2);
			if (ph == 0)
				hold_requests++;
			if (ph == 1) begin
				// sender stops until every outstanding result has drained
				queue_random_samples(RANDOM_PER_PHASE / 2);
				wait_idle();
				@(posedge clk);
				queue_random_samples(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
			end else begin
				queue_random_samples(RANDOM_PER_PHASE);
			end
			wait_idle();
		end
		no_idle = 1'b0;
		repeat (8) @(posedge clk);

		$display("Checked %0d results from %0d sample beats (%0d hits) over %0d settings",
			result_count, accepted_count, inside_count, settings_seen);
		$display("Settings spanned subpixel bits 0..15 and subsample log2 0..3; %0d mismatches",
			error_count);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("Timeout with %0d results still expected", expected_results.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
